// ----- hdl/tca_pkg.sv -----
`timescale 1ns / 1ps

package tca_pkg;

  // Field widths of the item and result ports.
  localparam int FUNC_W  = 2;
  localparam int ID_W    = 6;
  localparam int TOTAL_W = 16;

  // Default number of matrix rows and columns.
  localparam int MAX_NODES_DEF = 64;

  // Bits counted per cycle when a common-neighbor vector is reduced.
  localparam int POP_CH = 8;
  localparam int POP_W  = $clog2(POP_CH + 1);

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_LOAD_I,
    ST_SCAN,
    ST_AND,
    ST_POP,
    ST_DONE
  } state_t;

  function automatic logic [POP_W-1:0] popcnt(input logic [POP_CH-1:0] x);
    logic [POP_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < POP_CH; b++) begin
      acc = acc + POP_W'(x[b]);
    end
    return acc;
  endfunction

endpackage

// ----- hdl/triangle_count_adjacency.sv -----
`timescale 1ns / 1ps

// Triangle counter over an undirected graph held as a bit adjacency matrix.
// Input channel (in_valid / in_ready) carries one item per transfer: func 0
// adds the edge (node_u, node_v), func 1 counts triangles, func 2 clears the
// graph, func 3 is ignored. Only a count item gives a result, which leaves on
// the output channel (out_valid / out_ready) as out_triangle_total.
// An edge item is accepted while row u is read; then row u is written while
// row v is read, and then row v is written, all through the single row memory.
// A clear item runs the clearing pass, which zeroes one row per cycle. A
// count item is a walk of the matrix: each start row i is loaded, each column
// j is scanned, and for each edge (i, j) row j is read and the common
// neighbors above j are summed in chunks of 8 bits up to the last set one (at
// least one chunk). When the walk ends the result is registered.
// After reset the same clearing pass runs with in_ready low. The result sits
// in an output register; while the receiver stalls the block keeps taking
// edge and clear items, and a second count finishes its walk and then waits
// until the earlier result is transferred.
module triangle_count_adjacency #(
  parameter int MAX_NODES = tca_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tca_pkg::FUNC_W-1:0]  in_func,
  input  logic [tca_pkg::ID_W-1:0]    in_node_u,
  input  logic [tca_pkg::ID_W-1:0]    in_node_v,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tca_pkg::TOTAL_W-1:0] out_triangle_total
);

  localparam int W      = MAX_NODES;
  localparam int AW     = $clog2(MAX_NODES);
  localparam int SW     = $clog2(MAX_NODES + 1);
  localparam int CW     = SW + 1;
  localparam int CH     = tca_pkg::POP_CH;
  localparam int CHUNKS = (W + CH - 1) / CH;
  localparam int VW     = CHUNKS * CH;
  localparam int TW     = tca_pkg::TOTAL_W;

  tca_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [SW-1:0] span_r, span_nxt;
  logic [AW-1:0] u_r, u_nxt;
  logic [AW-1:0] v_r, v_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [W-1:0]  rowi_r, rowi_nxt;
  logic [VW-1:0] vec_r, vec_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [TW-1:0] out_total_r, out_total_nxt;

  // Row memory: one write port and one read port, read data registered.
  logic [W-1:0]  mem [MAX_NODES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [W-1:0]  rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    // A read of the row being written returns the new contents.
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rdata_r <= mem_wdata;
    end else begin
      rdata_r <= mem[mem_raddr];
    end
  end

  logic          in_xfer;
  logic          edge_ok;
  logic [SW-1:0] u_span, v_span;
  logic [W-1:0]  mask_gt_j;

  assign in_ready = (state_r == tca_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // An edge with an endpoint outside the matrix is dropped whole.
  assign edge_ok = (int'(in_node_u) < MAX_NODES) && (int'(in_node_v) < MAX_NODES);
  assign u_span  = SW'(in_node_u) + SW'(1);
  assign v_span  = SW'(in_node_v) + SW'(1);

  // Third corners k must lie above j.
  always_comb begin
    for (int k = 0; k < W; k++) begin
      mask_gt_j[k] = (k > int'(j_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    span_nxt      = span_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rowi_nxt      = rowi_r;
    vec_nxt       = vec_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tca_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == AW'(MAX_NODES - 1)) begin
          state_nxt = tca_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      tca_pkg::ST_IDLE: begin
        if (in_valid && (in_func == tca_pkg::FUNC_EDGE) && edge_ok) begin
          mem_raddr = AW'(in_node_u);
        end
        if (in_xfer) begin
          unique case (in_func)
            tca_pkg::FUNC_EDGE: begin
              if (edge_ok) begin
                u_nxt     = AW'(in_node_u);
                v_nxt     = AW'(in_node_v);
                span_nxt  = (u_span > span_r) ? u_span : span_r;
                if (v_span > span_nxt) begin
                  span_nxt = v_span;
                end
                state_nxt = tca_pkg::ST_EDGE_A;
              end
            end
            tca_pkg::FUNC_COUNT: begin
              total_nxt = '0;
              i_nxt     = '0;
              if (span_r < SW'(3)) begin
                state_nxt = tca_pkg::ST_DONE;
              end else begin
                state_nxt = tca_pkg::ST_LOAD_I;
              end
            end
            tca_pkg::FUNC_CLEAR: begin
              span_nxt     = '0;
              clr_addr_nxt = '0;
              state_nxt    = tca_pkg::ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      tca_pkg::ST_EDGE_A: begin
        // Row u is in rdata_r; set column v and fetch row v.
        mem_we    = 1'b1;
        mem_waddr = u_r;
        mem_wdata = rdata_r | (W'(1) << v_r);
        mem_raddr = v_r;
        state_nxt = tca_pkg::ST_EDGE_B;
      end

      tca_pkg::ST_EDGE_B: begin
        mem_we    = 1'b1;
        mem_waddr = v_r;
        mem_wdata = rdata_r | (W'(1) << u_r);
        state_nxt = tca_pkg::ST_IDLE;
      end

      tca_pkg::ST_LOAD_I: begin
        rowi_nxt  = rdata_r;
        j_nxt     = i_r + AW'(1);
        state_nxt = tca_pkg::ST_SCAN;
      end

      tca_pkg::ST_SCAN: begin
        if ((CW'(j_r) + CW'(1)) >= CW'(span_r)) begin
          // No k can follow this j: move to the next start row, or finish the walk.
          if ((CW'(i_r) + CW'(4)) <= CW'(span_r)) begin
            i_nxt     = i_r + AW'(1);
            mem_raddr = i_r + AW'(1);
            state_nxt = tca_pkg::ST_LOAD_I;
          end else begin
            state_nxt = tca_pkg::ST_DONE;
          end
        end else if (rowi_r[j_r]) begin
          mem_raddr = j_r;
          state_nxt = tca_pkg::ST_AND;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end

      tca_pkg::ST_AND: begin
        vec_nxt   = VW'(rowi_r & rdata_r & mask_gt_j);
        j_nxt     = j_r + AW'(1);
        state_nxt = tca_pkg::ST_POP;
      end

      tca_pkg::ST_POP: begin
        total_nxt = total_r + TW'(tca_pkg::popcnt(vec_r[CH-1:0]));
        vec_nxt   = vec_r >> CH;
        if ((vec_r >> CH) == '0) begin
          state_nxt = tca_pkg::ST_SCAN;
        end
      end

      tca_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = tca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tca_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      span_r      <= span_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    rowi_r      <= rowi_nxt;
    vec_r       <= vec_nxt;
    total_r     <= total_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_triangle_total = out_total_r;

  // The column scan never leaves the loaded node span.
  a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tca_pkg::ST_SCAN) |-> (CW'(j_r) < CW'(span_r)))
    else $error("column index outside node span");

  // A start row is only loaded while two more nodes can follow it.
  a_row_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tca_pkg::ST_LOAD_I) |-> ((CW'(i_r) + CW'(3)) <= CW'(span_r)))
    else $error("start row leaves no room for a triangle");

  // A finished count waits while the previous result is still held.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tca_pkg::ST_DONE && out_valid_r && !out_ready)
      |=> (state_r == tca_pkg::ST_DONE && out_valid_r))
    else $error("result overwritten before transfer");

endmodule

// ----- tb/triangle_count_adjacency_checker.sv -----
`timescale 1ns / 1ps

module triangle_count_adjacency_checker #(
  parameter int MAX_NODES = tca_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tca_pkg::FUNC_W-1:0]  in_func,
  input  logic [tca_pkg::ID_W-1:0]    in_node_u,
  input  logic [tca_pkg::ID_W-1:0]    in_node_v,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tca_pkg::TOTAL_W-1:0] out_triangle_total,
  output int                          fail_count,
  output int                          totals_pending
);

  typedef logic [MAX_NODES-1:0] row_t;

  row_t                        adj_rows [MAX_NODES];
  logic [tca_pkg::TOTAL_W-1:0] totals_due [$];
  int                          mismatches = 0;
  int                          due_count = 0;

  assign fail_count     = mismatches;
  assign totals_pending = due_count;

  // Rows only hold bits up to the highest node id seen, so the walk over all
  // rows gives the same total as a walk bounded by the node span. Each edge
  // (i, j) with i < j adds the common neighbors above j.
  function automatic logic [tca_pkg::TOTAL_W-1:0] predict_total();
    int unsigned total;
    row_t        above_j;
    total = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      for (int j = i + 1; j < MAX_NODES; j++) begin
        if (adj_rows[i][j]) begin
          above_j = ~((row_t'(1) << (j + 1)) - row_t'(1));
          total += $countones(adj_rows[i] & adj_rows[j] & above_j);
        end
      end
    end
    return total[tca_pkg::TOTAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (adj_rows[r]) adj_rows[r] = '0;
      totals_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          $error("triangle_total: no count pending, actual %0d", out_triangle_total);
          mismatches <= mismatches + 1;
        end else if (out_triangle_total !== totals_due[0]) begin
          $error("triangle_total mismatch: expected %0d, actual %0d",
                 totals_due[0], out_triangle_total);
          mismatches <= mismatches + 1;
          void'(totals_due.pop_front());
        end else begin
          void'(totals_due.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        case (in_func)
          tca_pkg::FUNC_EDGE: begin
            // An edge with an endpoint outside the matrix is dropped whole.
            if ((int'(in_node_u) < MAX_NODES) && (int'(in_node_v) < MAX_NODES)) begin
              adj_rows[in_node_u][in_node_v] = 1'b1;
              adj_rows[in_node_v][in_node_u] = 1'b1;
            end
          end
          tca_pkg::FUNC_COUNT: totals_due.push_back(predict_total());
          tca_pkg::FUNC_CLEAR: foreach (adj_rows[r]) adj_rows[r] = '0;
          default: ;
        endcase
      end
    end
    due_count <= totals_due.size();
  end

endmodule

// ----- tb/triangle_count_adjacency_tb.sv -----
`timescale 1ns / 1ps

// Top of the triangle counter bench. This module only makes stimulus and
// gives the verdict; the checker beside the block watches both channels,
// keeps its own copy of the adjacency matrix and compares every result.
module triangle_count_adjacency_tb;

  typedef logic [tca_pkg::FUNC_W-1:0] func_t;

  // Roughly the number of edge, count and clear transfers to send.
  localparam int ITEM_TARGET = 1500;
  // A count over a dense full-size graph is the slowest item, and a few
  // hundred counts are sent; the limit leaves a wide margin even for a run
  // full of such counts under heavy stalls.
  localparam int CYCLE_LIMIT = 50_000_000;
  // A clear item is the slowest item that gives no result; the drain wait
  // at the end covers its clearing pass with room to spare.
  localparam int DRAIN_CYCLES = tca_pkg::MAX_NODES_DEF + 16;
  // Percentage of cycles in which each side sits idle.
  localparam int IDLE_PCT = 32;
  // The one function code the block has no use for.
  localparam func_t FUNC_UNUSED = 2'd3;
  localparam int TOP_ID = (1 << tca_pkg::ID_W) - 1;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [tca_pkg::FUNC_W-1:0]  in_func;
  logic [tca_pkg::ID_W-1:0]    in_node_u;
  logic [tca_pkg::ID_W-1:0]    in_node_v;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [tca_pkg::TOTAL_W-1:0] out_triangle_total;

  // While steady is high neither side idles.
  logic        steady = 1'b0;
  int          fail_count;
  int          totals_pending;
  int          sent = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  triangle_count_adjacency dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_node_u          (in_node_u),
    .in_node_v          (in_node_v),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_triangle_total (out_triangle_total)
  );

  triangle_count_adjacency_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_node_u          (in_node_u),
    .in_node_v          (in_node_v),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_triangle_total (out_triangle_total),
    .fail_count         (fail_count),
    .totals_pending     (totals_pending)
  );

  // The receiver stalls at random, except during the steady stretch. Because
  // the result sits in an output register, stalls here also make a second
  // count wait behind an earlier, untransferred result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog against a hung handshake or a count that never finishes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Presents one item and holds it until the transfer. Idle cycles are only
  // inserted before valid rises, so valid never drops with an item pending.
  // Values read right after the edge are the ones the block saw at that edge.
  task automatic send_item(input func_t func, input int u, input int v);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_node_u <= u[tca_pkg::ID_W-1:0];
    in_node_v <= v[tca_pkg::ID_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Ignored items do not count toward the stimulus size.
    if (func != FUNC_UNUSED) sent++;
  endtask

  // Directed part: the empty graph, a triangle at each end of the id range,
  // a self-loop, a repeated edge, an ignored function code, node fields set
  // on count and clear items, and a small clique after a clear.
  task automatic run_directed();
    send_item(tca_pkg::FUNC_COUNT, TOP_ID, TOP_ID);
    send_item(FUNC_UNUSED, 21, 42);
    send_item(tca_pkg::FUNC_EDGE, 0, 1);
    send_item(tca_pkg::FUNC_EDGE, 1, 2);
    send_item(tca_pkg::FUNC_EDGE, 2, 0);
    send_item(tca_pkg::FUNC_EDGE, 2, 2);
    send_item(tca_pkg::FUNC_EDGE, 1, 0);
    send_item(tca_pkg::FUNC_EDGE, TOP_ID, TOP_ID - 1);
    send_item(tca_pkg::FUNC_EDGE, TOP_ID - 1, TOP_ID - 2);
    send_item(tca_pkg::FUNC_EDGE, TOP_ID - 2, TOP_ID);
    send_item(tca_pkg::FUNC_EDGE, 0, TOP_ID);
    send_item(tca_pkg::FUNC_COUNT, 0, 0);
    send_item(tca_pkg::FUNC_CLEAR, TOP_ID, TOP_ID);
    send_item(tca_pkg::FUNC_COUNT, 42, 21);
    // Four nodes, all connected: four triangles.
    send_item(tca_pkg::FUNC_EDGE, 0, 1);
    send_item(tca_pkg::FUNC_EDGE, 0, 2);
    send_item(tca_pkg::FUNC_EDGE, 1, 2);
    send_item(tca_pkg::FUNC_EDGE, 0, 3);
    send_item(tca_pkg::FUNC_EDGE, 1, 3);
    send_item(tca_pkg::FUNC_EDGE, 2, 3);
    send_item(tca_pkg::FUNC_COUNT, TOP_ID, 0);
  endtask

  // Random part. Most rounds are well-formed: usually a clear, then a burst
  // of edges over a small id range so that the graphs come out dense and
  // full of triangles, then one or two counts. Now and then the range is the
  // full one, which makes the count walk every row. A tenth of the rounds is
  // noise with any function code, including counts on whatever is loaded.
  task automatic run_random();
    int top_id;
    int edge_total;
    int u;
    int v;
    while (sent < ITEM_TARGET) begin
      steady <= (sent >= 700) && (sent < 1000);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(6, 1)) begin
          send_item(func_t'($urandom_range(3)), $urandom_range(TOP_ID),
                    $urandom_range(TOP_ID));
        end
      end else begin
        if ($urandom_range(3) != 0) begin
          send_item(tca_pkg::FUNC_CLEAR, $urandom_range(TOP_ID), $urandom_range(TOP_ID));
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: top_id = $urandom_range(11, 3);
          6, 7, 8:          top_id = $urandom_range(31, 12);
          default:          top_id = TOP_ID;
        endcase
        edge_total = $urandom_range(40, 1);
        for (int e = 0; e < edge_total; e++) begin
          // An occasional count while the graph is still being loaded.
          if ($urandom_range(15) == 0) begin
            send_item(tca_pkg::FUNC_COUNT, $urandom_range(TOP_ID), $urandom_range(TOP_ID));
          end
          u = $urandom_range(top_id);
          v = ($urandom_range(19) == 0) ? u : $urandom_range(top_id);
          send_item(tca_pkg::FUNC_EDGE, u, v);
        end
        repeat ($urandom_range(2, 1)) begin
          send_item(tca_pkg::FUNC_COUNT, $urandom_range(TOP_ID), $urandom_range(TOP_ID));
        end
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_func   <= tca_pkg::FUNC_EDGE;
    in_node_u <= '0;
    in_node_v <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The block runs its clearing pass after reset with in_ready low; the
    // first transfer simply waits for it.
    run_directed();
    run_random();
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // The checker's pending count is registered, so the wait first lets it take in the last transfer.
    @(posedge clk);
    while (totals_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && totals_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
